@@ rtl/dbq_pkg.sv @@
// package for the degree bucket linked queue
// holds widths, sizes, opcodes, payload structs and the sequencer state type
// no dependencies
package dbq_pkg;

   localparam int COL_W   = 10;
   localparam int BKT_W   = 6;
   localparam int OP_W    = 2;
   localparam int COLUMNS = 1024;
   localparam int BUCKETS = 64;
   localparam int COL_AW  = $clog2(COLUMNS);
   localparam int BKT_AW  = $clog2(BUCKETS);

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [COL_W-1:0] column;
      logic [BKT_W-1:0] bucket;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] head_column;
      logic [BKT_W-1:0] found_bucket;
      logic             found;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_LINK,
      ST_INS_BACK,
      ST_RM_LINK,
      ST_RM_CLR,
      ST_FIND
   } state_type;

endpackage

@@ rtl/degree_bucket_linked_queue.sv @@
// top level of the degree bucket linked queue: sequencer over three rams
// depends on dbq_pkg and dbq_ram
// usage:
//   a request (op, column, bucket) transfers at a rising edge with start high
//   and busy low. insert pushes a column at the head of a bucket, remove
//   unlinks a column from the named bucket, find scans down from a level to
//   the highest non-empty bucket. each request gives exactly one result on
//   rsp_data, marked by rsp_strobe for one cycle; the receiver cannot stall.
// steps, paced by the one read port of each ram: insert (ST_INS_LINK) links
//   the column and writes the head, then (ST_INS_BACK) back-links the old head
//   when the bucket was non-empty; remove (ST_RM_LINK) relinks the neighbours,
//   then (ST_RM_CLR) clears the column's links; find (ST_FIND) reads bucket heads
//   downward until one is non-empty or bucket 0 is reached; no operation or an ignored request is answered from idle.
// busy is high for the whole operation; a new request can transfer in the
//   cycle its predecessor's result is strobed.
// reset clears the sequencer and the per-bucket valid bits, so every bucket
//   reads empty; link rams are not cleared and there is no clearing pass.
module degree_bucket_linked_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dbq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dbq_pkg::rsp_type rsp_data
);
   import dbq_pkg::*;

   state_type         state_ff, state_in;
   logic [COL_AW-1:0] col_ff, col_in;
   logic [BKT_AW-1:0] lvl_ff, lvl_in;
   logic [COL_W-1:0]  aux_ff, aux_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic [BUCKETS-1:0] hd_valid_ff;
   logic               hd_rvld_ff;

   logic              hd_we;
   logic [BKT_AW-1:0] hd_waddr, hd_raddr;
   logic [COL_W-1:0]  hd_wdata, hd_rdata, head_val;

   logic              nx_we, pv_we;
   logic [COL_AW-1:0] nx_waddr, pv_waddr, lk_raddr;
   logic [COL_W-1:0]  nx_wdata, pv_wdata, nx_rdata, pv_rdata;

   logic              col_ok, bkt_ok;
   logic [BKT_AW-1:0] find_lvl;

   dbq_ram #(.WIDTH(COL_W), .DEPTH(BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (hd_we),
      .wr_addr (hd_waddr),
      .wr_data (hd_wdata),
      .rd_addr (hd_raddr),
      .rd_data (hd_rdata)
   );

   dbq_ram #(.WIDTH(COL_W), .DEPTH(COLUMNS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (lk_raddr),
      .rd_data (nx_rdata)
   );

   dbq_ram #(.WIDTH(COL_W), .DEPTH(COLUMNS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_addr (lk_raddr),
      .rd_data (pv_rdata)
   );

   assign head_val = hd_rvld_ff ? hd_rdata : '0;
   assign col_ok   = (req_data.column != '0) && (int'(req_data.column) < COLUMNS);
   assign bkt_ok   = int'(req_data.bucket) < BUCKETS;
   assign find_lvl = bkt_ok ? req_data.bucket[BKT_AW-1:0] : BKT_AW'(BUCKETS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         hd_valid_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (hd_we) begin
            hd_valid_ff[hd_waddr] <= 1'b1;
         end
      end
      col_ff     <= col_in;
      lvl_ff     <= lvl_in;
      aux_ff     <= aux_in;
      rsp_ff     <= rsp_in;
      hd_rvld_ff <= hd_valid_ff[hd_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      lvl_in        = lvl_ff;
      aux_in        = aux_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      hd_we         = 1'b0;
      hd_waddr      = lvl_ff;
      hd_wdata      = '0;
      hd_raddr      = lvl_ff;
      nx_we         = 1'b0;
      nx_waddr      = col_ff;
      nx_wdata      = '0;
      pv_we         = 1'b0;
      pv_waddr      = col_ff;
      pv_wdata      = '0;
      lk_raddr      = req_data.column[COL_AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            hd_raddr = (req_data.op == OP_FIND) ? find_lvl : req_data.bucket[BKT_AW-1:0];
            if (start) begin
               col_in = req_data.column[COL_AW-1:0];
               lvl_in = hd_raddr;
               if (req_data.op == OP_INSERT && col_ok && bkt_ok) begin
                  state_in = ST_INS_LINK;
               end else if (req_data.op == OP_REMOVE && col_ok && bkt_ok) begin
                  state_in = ST_RM_LINK;
               end else if (req_data.op == OP_FIND) begin
                  state_in = ST_FIND;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         ST_INS_LINK: begin
            aux_in   = head_val;
            pv_we    = 1'b1;
            nx_we    = 1'b1;
            nx_wdata = head_val;
            hd_we    = 1'b1;
            hd_wdata = COL_W'(col_ff);
            if (head_val != '0) begin
               state_in = ST_INS_BACK;
            end else begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
            end
         end
         ST_INS_BACK: begin
            pv_we         = 1'b1;
            pv_waddr      = aux_ff[COL_AW-1:0];
            pv_wdata      = COL_W'(col_ff);
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
         end
         ST_RM_LINK: begin
            // p is the previous link, n the next link of the column
            if (pv_rdata == '0) begin
               hd_we    = 1'b1;
               hd_wdata = nx_rdata;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = pv_rdata[COL_AW-1:0];
               nx_wdata = nx_rdata;
            end
            if (nx_rdata != '0) begin
               pv_we    = 1'b1;
               pv_waddr = nx_rdata[COL_AW-1:0];
               pv_wdata = pv_rdata;
            end
            state_in = ST_RM_CLR;
         end
         ST_RM_CLR: begin
            nx_we         = 1'b1;
            pv_we         = 1'b1;
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
         end
         ST_FIND: begin
            if (head_val != '0) begin
               rsp_in.head_column  = head_val;
               rsp_in.found_bucket = BKT_W'(lvl_ff);
               rsp_in.found        = 1'b1;
               rsp_strobe_in       = 1'b1;
               state_in            = ST_IDLE;
            end else if (lvl_ff == '0) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               hd_raddr = lvl_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_found_has_head: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.found |-> rsp_data.head_column != '0)
      else $error("found result with empty head");

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while busy");

   a_transfer_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe || busy)
      else $error("request transfer lost");

   a_head_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      hd_we |=> hd_valid_ff[$past(hd_waddr)])
      else $error("head write did not mark bucket valid");

endmodule

@@ rtl/dbq_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
module dbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/degree_bucket_linked_queue_test.sv @@
// testbench for degree_bucket_linked_queue: directed and random insert, remove and find
// requests checked against an in-bench model of the bucket lists
// depends on dbq_pkg and the degree_bucket_linked_queue rtl
`timescale 1ns / 1ps

module degree_bucket_linked_queue_test;
   import dbq_pkg::*;

   localparam logic [OP_W-1:0] OP_NOP = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_LIVE   = 48;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   degree_bucket_linked_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // model of the bucket lists
   logic [COL_W-1:0] head_of [BUCKETS];
   logic [COL_W-1:0] next_of [COLUMNS];
   logic [COL_W-1:0] prev_of [COLUMNS];

   // bench view of which bucket each column was put in, -1 when unlinked
   int col_home [COLUMNS];
   int live_cols [$];

   rsp_type expected_rsp [$];

   int failures    = 0;
   int sent_count  = 0;
   int rsp_count   = 0;
   int find_hits   = 0;
   int find_misses = 0;
   int burst_left  = 0;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic queue_apply(input req_type r, output rsp_type a);
      int c;
      int b;
      int lvl;
      logic [COL_W-1:0] h;
      logic [COL_W-1:0] p;
      logic [COL_W-1:0] n;
      c = r.column;
      b = r.bucket;
      a = '0;
      if (r.op == OP_INSERT || r.op == OP_REMOVE) begin
         if (c != 0 && c < COLUMNS && b < BUCKETS) begin
            if (r.op == OP_INSERT) begin
               h = head_of[b];
               prev_of[c] = '0;
               next_of[c] = h;
               if (h != 0) prev_of[h] = c[COL_W-1:0];
               head_of[b] = c[COL_W-1:0];
            end else begin
               p = prev_of[c];
               n = next_of[c];
               if (p == 0) head_of[b] = n;
               else next_of[p] = n;
               if (n != 0) prev_of[n] = p;
               next_of[c] = '0;
               prev_of[c] = '0;
            end
         end
      end else if (r.op == OP_FIND) begin
         lvl = (b >= BUCKETS) ? BUCKETS - 1 : b;
         while (1) begin
            if (head_of[lvl] != 0) begin
               a.head_column  = head_of[lvl];
               a.found_bucket = lvl[BKT_W-1:0];
               a.found        = 1'b1;
               break;
            end
            if (lvl == 0) break;
            lvl--;
         end
         if (a.found) find_hits++;
         else find_misses++;
      end
   endtask

   // one request transfer, followed by the sender's burst and gap pattern
   task automatic send_op(input logic [OP_W-1:0] op, input int column, input int bucket);
      req_type r;
      rsp_type a;
      r.op     = op;
      r.column = column[COL_W-1:0];
      r.bucket = bucket[BKT_W-1:0];
      req_data = r;
      start    = 1'b1;
      do @(posedge clock); while (busy);
      queue_apply(r, a);
      expected_rsp.push_back(a);
      sent_count++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start = 1'b0;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 15)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 11);
      end
   endtask

   task automatic track_insert(input int c, input int b);
      if (col_home[c] < 0) live_cols.push_back(c);
      col_home[c] = b;
      send_op(OP_INSERT, c, b);
   endtask

   task automatic track_remove(input int idx, input int b);
      int c;
      c = live_cols[idx];
      live_cols.delete(idx);
      col_home[c] = -1;
      send_op(OP_REMOVE, c, b);
   endtask

   function automatic int pick_bucket();
      int hot [4] = '{0, 21, 42, 63};
      if ($urandom_range(0, 9) < 4) return hot[$urandom_range(0, 3)];
      return $urandom_range(0, BUCKETS - 1);
   endfunction

   function automatic int pick_free_col();
      int c;
      do c = $urandom_range(1, COLUMNS - 1); while (col_home[c] >= 0);
      return c;
   endfunction

   task automatic test_empty_queue();
      send_op(OP_FIND, 0, BUCKETS - 1);
      send_op(OP_FIND, COLUMNS - 1, 0);
      send_op(OP_NOP, 777, 33);
      send_op(OP_INSERT, 0, 5);
      send_op(OP_REMOVE, 0, 5);
      send_op(OP_FIND, 0, 5);
   endtask

   task automatic test_list_edges();
      send_op(OP_INSERT, COLUMNS - 1, BUCKETS - 1);
      send_op(OP_INSERT, 1, 0);
      send_op(OP_FIND, 0, BUCKETS - 1);
      send_op(OP_FIND, 0, BUCKETS - 2);
      send_op(OP_INSERT, 512, BUCKETS - 1);
      send_op(OP_INSERT, 341, BUCKETS - 1);
      send_op(OP_FIND, 0, BUCKETS - 1);
      // middle, then head, then last of bucket 63
      send_op(OP_REMOVE, 512, BUCKETS - 1);
      send_op(OP_REMOVE, 341, BUCKETS - 1);
      send_op(OP_REMOVE, COLUMNS - 1, BUCKETS - 1);
      send_op(OP_FIND, 0, BUCKETS - 1);
      // wrong bucket named on remove
      send_op(OP_REMOVE, 1, BUCKETS - 1);
      send_op(OP_FIND, 0, 0);
      // column inserted twice into the same bucket
      send_op(OP_INSERT, 682, 42);
      send_op(OP_INSERT, 682, 42);
      send_op(OP_FIND, 0, 50);
      send_op(OP_REMOVE, 682, 42);
      send_op(OP_FIND, 0, BUCKETS - 1);
   endtask

   task automatic test_random_ops(input int count);
      int kind;
      int idx;
      int c;
      repeat (count) begin
         kind = $urandom_range(0, 99);
         if (kind < 38 && live_cols.size() >= MAX_LIVE) kind = 50;
         if (kind >= 38 && kind < 63 && live_cols.size() == 0) kind = 0;
         if (kind < 38) begin
            track_insert(pick_free_col(), pick_bucket());
         end else if (kind < 63) begin
            idx = $urandom_range(0, live_cols.size() - 1);
            track_remove(idx, col_home[live_cols[idx]]);
         end else if (kind < 88) begin
            send_op(OP_FIND, $urandom_range(0, COLUMNS - 1), $urandom_range(0, BUCKETS - 1));
         end else begin
            case ($urandom_range(0, 3))
               0: send_op(OP_NOP, $urandom_range(0, COLUMNS - 1), $urandom_range(0, BUCKETS - 1));
               1: send_op($urandom_range(0, 1) ? OP_INSERT : OP_REMOVE, 0,
                          $urandom_range(0, BUCKETS - 1));
               2: begin
                  if (live_cols.size() > 0) begin
                     idx = $urandom_range(0, live_cols.size() - 1);
                     track_remove(idx, $urandom_range(0, BUCKETS - 1));
                  end
               end
               default: begin
                  if (live_cols.size() > 0) begin
                     c = live_cols[$urandom_range(0, live_cols.size() - 1)];
                     track_insert(c, pick_bucket());
                  end
               end
            endcase
         end
      end
   endtask

   task automatic test_drain();
      int idx;
      while (live_cols.size() > 0) begin
         idx = $urandom_range(0, live_cols.size() - 1);
         track_remove(idx, col_home[live_cols[idx]]);
         if ($urandom_range(0, 3) == 0) send_op(OP_FIND, 0, $urandom_range(0, BUCKETS - 1));
      end
      send_op(OP_FIND, 0, BUCKETS - 1);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $error("result with no request outstanding: %h", rsp_data);
            failures++;
         end else begin
            want = expected_rsp.pop_front();
            rsp_count++;
            if (rsp_data.head_column !== want.head_column) begin
               $error("head_column expected %0d actual %0d", want.head_column,
                      rsp_data.head_column);
               failures++;
            end
            if (rsp_data.found_bucket !== want.found_bucket) begin
               $error("found_bucket expected %0d actual %0d", want.found_bucket,
                      rsp_data.found_bucket);
               failures++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found expected %0d actual %0d", want.found, rsp_data.found);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_rsp.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      for (int i = 0; i < BUCKETS; i++) head_of[i] = '0;
      for (int i = 0; i < COLUMNS; i++) begin
         next_of[i]  = '0;
         prev_of[i]  = '0;
         col_home[i] = -1;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_list_edges();
      test_random_ops(300);
      test_drain();
      test_random_ops(300);
      test_drain();
      test_random_ops(300);

      start = 1'b0;
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (BUCKETS + 8) @(posedge clock);

      $display("%0d requests sent, %0d results checked", sent_count, rsp_count);
      $display("finds: %0d hit a non-empty bucket, %0d found nothing", find_hits, find_misses);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/dbq_pkg.sv
rtl/dbq_ram.sv
rtl/degree_bucket_linked_queue.sv
tb/degree_bucket_linked_queue_test.sv
